[design/assert_macros.svh]
// Assertion macros used by the checker file of the culling block.
// No dependencies; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FBC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fbc_pkg.sv]
// Package for the frustum box culling block: widths, word layout and types.
// Used by every module of the block; depends on nothing.
package fbc_pkg;

  // Field widths: matrix entries Q7.16, coordinates Q15.8.
  localparam int ENTRY_BITS = 24;
  localparam int COORD_BITS = 24;
  localparam int COORD_FRAC = 8;
  localparam int ROW_BITS   = 2;
  localparam int NUM_COLS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;

  // Arithmetic widths.
  localparam int NORM_W = ENTRY_BITS + 1;
  localparam int PROD_W = NORM_W + COORD_BITS;
  localparam int OFS_W  = NORM_W + COORD_FRAC;
  localparam int SUM_W  = PROD_W + 2;

  // Input word layout, lowest bit first.
  localparam int ROW_LSB      = 0;
  localparam int COL_LSB      = ROW_LSB + ROW_BITS;
  localparam int BOX_LSB      = COL_LSB + NUM_COLS * ENTRY_BITS;
  localparam int IN_BITS      = BOX_LSB + 2 * NUM_AXES * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } opcode_e;

  typedef logic signed [ENTRY_BITS-1:0] entry_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]     norm_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [OFS_W-1:0]      ofs_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef entry_t [NUM_COLS-1:0] row_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0] hi;
    coord_t [NUM_AXES-1:0] lo;
  } box_t;

  // Registered partial results of one plane.
  typedef struct packed {
    prod_t [NUM_AXES-1:0] prod;
    ofs_t                 ofs;
  } plane_prod_t;

endpackage

[design/fbc_plane_mul.sv]
// One frustum plane: forms the plane from two matrix rows, picks the far box
// corner and multiplies it out. Depends on fbc_pkg.
module fbc_plane_mul import fbc_pkg::*; (
  input  row_t        row3_i,
  input  row_t        rowk_i,
  input  logic        neg_i,
  input  box_t        box_i,
  output plane_prod_t prod_o
);

  // Plane coefficients, corner choice and products per axis.
  always_comb begin
    norm_t  n;
    coord_t p;
    norm_t  d;
    for (int j = 0; j < NUM_AXES; j++) begin
      n = neg_i ? norm_t'($signed(row3_i[j])) - norm_t'($signed(rowk_i[j]))
                : norm_t'($signed(row3_i[j])) + norm_t'($signed(rowk_i[j]));
      // A non-negative normal component takes the box maximum.
      p = n[NORM_W-1] ? $signed(box_i.lo[j]) : $signed(box_i.hi[j]);
      prod_o.prod[j] = prod_t'(n * p);
    end
    d = neg_i ? norm_t'($signed(row3_i[NUM_COLS-1])) - norm_t'($signed(rowk_i[NUM_COLS-1]))
              : norm_t'($signed(row3_i[NUM_COLS-1])) + norm_t'($signed(rowk_i[NUM_COLS-1]));
    // Offset scaled to the product's fraction.
    prod_o.ofs = {d, {COORD_FRAC{1'b0}}};
  end

endmodule

[design/fbc_plane_test.sv]
// Sums the registered products of one plane and tests the sign.
// Depends on fbc_pkg.
module fbc_plane_test import fbc_pkg::*; (
  input  plane_prod_t prod_i,
  output logic        outside_o
);

  sum_t distance;

  // Signed distance of the far corner; negative means outside.
  always_comb begin
    distance = sum_t'($signed(prod_i.ofs));
    for (int j = 0; j < NUM_AXES; j++) begin
      distance = distance + sum_t'($signed(prod_i.prod[j]));
    end
  end

  assign outside_o = distance[SUM_W-1];

endmodule

[design/frustum_box_cull.sv]
// Frustum box culling: keeps a 4x4 view-projection matrix loaded one row per
// word and tests axis-aligned boxes against the six planes derived from it.
// Depends on fbc_pkg, fbc_plane_mul and fbc_plane_test.
//
// A word with tuser = 0 loads one matrix row and returns nothing; a word with
// tuser = 1 tests one box and returns one word, bit 0 high when the box is
// inside or crosses the frustum. The block takes one word every cycle while any
// stage is empty or the output is ready; a result passes the input,
// product and result registers; the six planes are evaluated in parallel with
// eighteen 25x24 multipliers in the middle stage. Stages advance on their own,
// so words keep entering while a result waits at the output until the empty
// stages fill. The matrix is zero after reset, which makes every box visible
// until rows are loaded; a test right after a load already sees the new row.
module frustum_box_cull import fbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: row_index, col0, col1, col2, col3, box_min_x, box_min_y, box_min_z,
  //        box_max_x, box_max_y, box_max_z, zero padding
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: opcode
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: visible, zero padding
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                  en1, en2, en3;
  logic                  v1_q, v2_q, v3_q;
  opcode_e               op1_q;
  logic [ROW_BITS-1:0]   row1_q;
  row_t                  cols1_q;
  box_t                  box1_q;
  row_t                  cols_d;
  box_t                  box_d;
  row_t                  matrix_q [NUM_COLS];
  plane_prod_t [NUM_PLANES-1:0] prod_d, prod2_q;
  logic [NUM_PLANES-1:0] outside;
  logic                  vis3_q;

  // Each stage moves when the one after it is empty or moving.
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  // Unpack the incoming word.
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      cols_d[c] = s_axis_tdata[COL_LSB + c*ENTRY_BITS +: ENTRY_BITS];
    end
    for (int j = 0; j < NUM_AXES; j++) begin
      box_d.lo[j] = s_axis_tdata[BOX_LSB + j*COORD_BITS +: COORD_BITS];
      box_d.hi[j] = s_axis_tdata[BOX_LSB + (NUM_AXES + j)*COORD_BITS +: COORD_BITS];
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      op1_q   <= opcode_e'(s_axis_tuser);
      row1_q  <= s_axis_tdata[ROW_LSB +: ROW_BITS];
      cols1_q <= cols_d;
      box1_q  <= box_d;
    end
  end

  // Matrix store, written as a load word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_COLS; r++) begin
        matrix_q[r] <= '0;
      end
    end else if (v1_q && (op1_q == OP_LOAD) && en2) begin
      matrix_q[row1_q] <= cols1_q;
    end
  end

  // Six planes: row 3 plus and minus rows 0, 1 and 2.
  for (genvar gi = 0; gi < NUM_PLANES; gi++) begin : g_plane
    localparam int K = gi / 2;
    localparam bit NEG = (gi % 2) != 0;

    fbc_plane_mul u_mul (
      .row3_i (matrix_q[NUM_COLS-1]),
      .rowk_i (matrix_q[K]),
      .neg_i  (NEG),
      .box_i  (box1_q),
      .prod_o (prod_d[gi])
    );

    fbc_plane_test u_test (
      .prod_i    (prod2_q[gi]),
      .outside_o (outside[gi])
    );
  end

  // Product register; only test words go on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && (op1_q == OP_TEST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod2_q <= prod_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      vis3_q <= ~(|outside);
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, vis3_q};

endmodule

[design/fbc_checker.sv]
// Port-level checks for the frustum box culling block, bound to the top level.
// Depends on fbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbc_checker import fbc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result word stays put.
  `FBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // With the output empty nothing can stall the input.
  `FBC_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Only bit 0 of a result carries information.
  `FBC_ASSERT_IMPL(a_out_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0, "result padding not zero")

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);
